// ===== design/bdsl_pkg.sv =====
// Package for the button debounce and short/long press unit.
// Holds the transaction structs, register indexes, widths and reset values.
// No dependencies.
`default_nettype none

package bdsl_pkg;

    localparam int DEF_NUM_BUTTONS = 3;
    localparam int DEF_TIME_BITS   = 32;

    localparam int NOW_W     = 32;
    localparam int FILTER_W  = 16;
    localparam int LONG_W    = 16;
    localparam int WINDOW_W  = 24;
    localparam int EVENT_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TIME     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVITY_WINDOW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_UP_DOWN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_ENABLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_ENABLE     = 3'd5;

    localparam logic [FILTER_W-1:0] RST_FILTER_TIME = 16'd50;
    localparam logic [LONG_W-1:0]   RST_LONG_TIME   = 16'd1000;

    typedef struct packed {
        logic [NOW_W-1:0] now_ms;
        logic             level_up;
        logic             level_sel;
        logic             level_dn;
    } t_in_item;

    typedef struct packed {
        logic [EVENT_W-1:0] short_press;
        logic [EVENT_W-1:0] long_press;
        logic               any_pressed;
        logic               recently_active;
    } t_out_item;

endpackage

`default_nettype wire

// ===== design/button_debounce_short_long_press_unit.sv =====
// Top level of the button debounce and short/long press unit.
// Depends on bdsl_pkg for the transaction structs and register indexes.
//
// The unit takes one sample transaction per clock unless the output stalls:
// a millisecond time stamp and the active-low levels of the up, select and
// down buttons. Each sample lands in an input register, all buttons are
// evaluated side by side by a short path of subtracts and compares, and the
// result goes to an output register once that is free or being read; one
// transaction per clock is sustained while the output is read. The longest path
// is the filter subtract and compare followed by the press-time subtract and
// compare of a button. The user must write registers through the plain write
// port while no transaction is in flight; the block does not enforce this.
`default_nettype none

module button_debounce_short_long_press_unit #(
    parameter int NUM_BUTTONS = bdsl_pkg::DEF_NUM_BUTTONS,
    parameter int TIME_BITS   = bdsl_pkg::DEF_TIME_BITS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [bdsl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [bdsl_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire  bdsl_pkg::t_in_item         i_in_item,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output bdsl_pkg::t_out_item              o_out_item
);
    import bdsl_pkg::*;

    localparam int CMP_W = (TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W;
    localparam int EXT_B = (NUM_BUTTONS > EVENT_W) ? NUM_BUTTONS : EVENT_W;

    logic [FILTER_W-1:0] r_filter_time;
    logic [LONG_W-1:0]   r_long_time;
    logic [WINDOW_W-1:0] r_window;
    logic                r_swap;
    logic [EVENT_W-1:0]  r_short_en;
    logic [EVENT_W-1:0]  r_long_en;

    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    logic      r_out_valid;
    t_out_item n_out;
    logic      w_adv;

    logic [TIME_BITS-1:0] w_now;
    logic [EXT_B-1:0]     w_short;
    logic [EXT_B-1:0]     w_long;
    logic [EXT_B-1:0]     w_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_time <= RST_FILTER_TIME;
            r_long_time   <= RST_LONG_TIME;
            r_window      <= '0;
            r_swap        <= 1'b0;
            r_short_en    <= '0;
            r_long_en     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FILTER_TIME:     r_filter_time <= i_cfg_data[FILTER_W-1:0];
                CFG_LONG_TIME:       r_long_time   <= i_cfg_data[LONG_W-1:0];
                CFG_ACTIVITY_WINDOW: r_window      <= i_cfg_data[WINDOW_W-1:0];
                CFG_SWAP_UP_DOWN:    r_swap        <= i_cfg_data[0];
                CFG_SHORT_ENABLE:    r_short_en    <= i_cfg_data[EVENT_W-1:0];
                CFG_LONG_ENABLE:     r_long_en     <= i_cfg_data[EVENT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign w_now = TIME_BITS'(r_in.now_ms);

    genvar gi;
    generate
        for (gi = 0; gi < EXT_B; gi++) begin : g_btn
            if (gi < NUM_BUTTONS) begin : g_live
                logic                 r_stable;
                logic [TIME_BITS-1:0] r_change_time;
                logic [TIME_BITS-1:0] r_press_time;
                logic                 r_held;
                logic                 r_fired;
                logic                 n_stable;
                logic [TIME_BITS-1:0] n_change_time;
                logic [TIME_BITS-1:0] n_press_time;
                logic                 n_held;
                logic                 n_fired;
                logic                 w_lvl;
                logic                 w_sen;
                logic                 w_len;
                logic [TIME_BITS-1:0] w_el_chg;
                logic [TIME_BITS-1:0] w_el_press;
                logic                 w_filt_ok;
                logic                 w_sp;
                logic                 w_lp;
                logic                 w_act;

                if (gi == 0) begin : g_lvl
                    assign w_lvl = r_swap ? r_in.level_dn : r_in.level_up;
                end else if (gi == 1) begin : g_lvl
                    assign w_lvl = r_in.level_sel;
                end else if (gi == 2) begin : g_lvl
                    assign w_lvl = r_swap ? r_in.level_up : r_in.level_dn;
                end else begin : g_lvl
                    assign w_lvl = 1'b1;
                end

                if (gi < EVENT_W) begin : g_en
                    assign w_sen = r_short_en[gi];
                    assign w_len = r_long_en[gi];
                end else begin : g_en
                    assign w_sen = 1'b0;
                    assign w_len = 1'b0;
                end

                assign w_el_chg  = w_now - r_change_time;
                assign w_filt_ok = CMP_W'(w_el_chg) > CMP_W'(r_filter_time);

                always_comb begin
                    n_stable       = r_stable;
                    n_change_time  = r_change_time;
                    n_press_time   = r_press_time;
                    n_held         = r_held;
                    n_fired        = r_fired;
                    w_sp           = 1'b0;
                    w_lp           = 1'b0;
                    if (w_lvl != r_stable) begin
                        if (!w_lvl && w_filt_ok) begin
                            n_press_time = w_now;
                            n_held       = 1'b1;
                            w_sp         = w_sen && !w_len;
                        end
                        n_change_time = w_now;
                        n_stable      = w_lvl;
                    end else if (w_lvl && r_held && w_filt_ok) begin
                        w_sp    = !r_fired && w_sen && w_len;
                        n_held  = 1'b0;
                        n_fired = 1'b0;
                    end
                    w_el_press = w_now - n_press_time;
                    if (!n_fired && w_len && !w_lvl && n_held &&
                        (CMP_W'(w_el_press) > CMP_W'(r_long_time))) begin
                        n_fired = 1'b1;
                        w_lp    = 1'b1;
                    end
                    w_act = (w_lvl != r_stable) ||
                            (CMP_W'(w_el_chg) <= CMP_W'(r_window));
                end

                assign w_short[gi]  = w_sp;
                assign w_long[gi]   = w_lp;
                assign w_active[gi] = w_act;

                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_stable      <= 1'b1;
                        r_change_time <= '0;
                        r_press_time  <= '0;
                        r_held        <= 1'b0;
                        r_fired       <= 1'b0;
                    end else if (w_adv) begin
                        r_stable      <= n_stable;
                        r_change_time <= n_change_time;
                        r_press_time  <= n_press_time;
                        r_held        <= n_held;
                        r_fired       <= n_fired;
                    end
                end
            end else begin : g_pad
                assign w_short[gi]  = 1'b0;
                assign w_long[gi]   = 1'b0;
                assign w_active[gi] = 1'b0;
            end
        end
    endgenerate

    always_comb begin
        n_out.short_press     = w_short[EVENT_W-1:0];
        n_out.long_press      = w_long[EVENT_W-1:0];
        n_out.any_pressed     = !r_in.level_up || !r_in.level_sel || !r_in.level_dn;
        n_out.recently_active = |w_active;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// ===== sim/tb_button_debounce_short_long_press_unit.sv =====
// Self-checking testbench for the button debounce and short/long press unit.
// Drives sample transactions, predicts every result and checks each one.
// Depends on bdsl_pkg and button_debounce_short_long_press_unit.
`timescale 1ns / 100ps

module tb_button_debounce_short_long_press_unit;

    import bdsl_pkg::*;

    localparam int NUM_PHASES      = 7;
    localparam int SAMPLES_PER_SET = 185;
    localparam int HOLDOFF_CYCLES  = 300;
    localparam int DRAIN_CYCLES    = 4;
    localparam int SETTLE_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS     = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_item             in_item = '0;
    logic                 o_out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            o_out_item;

    button_debounce_short_long_press_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of the registers and the per-button state.
    logic [FILTER_W-1:0] filt_ms;
    logic [LONG_W-1:0]   hold_ms;
    logic [WINDOW_W-1:0] window_ms;
    logic                swap_sel;
    logic [EVENT_W-1:0]  short_en;
    logic [EVENT_W-1:0]  long_en;
    logic                stable_lvl [3];
    logic [NOW_W-1:0]    chg_ms [3];
    logic [NOW_W-1:0]    press_ms [3];
    logic                held_q [3];
    logic                fired_q [3];

    t_in_item  pending_samples [$];
    t_out_item press_results [$];

    logic [NOW_W-1:0] cur_ms;
    logic [2:0]       pin_lvl = 3'b111;
    bit               in_fire = 1'b0;
    bit               no_idle = 1'b0;
    int               send_gap = 0;
    int               stall_left = 0;
    int               holdoff_asked = 0;
    int               holdoff_taken = 0;
    int               holdoff_left = 0;
    int               idle_cycles = 0;
    int               mismatch_cnt = 0;
    int               checked_cnt = 0;
    int               sent_cnt = 0;
    int               short_cnt = 0;
    int               long_cnt = 0;
    int               settings_cnt = 1;

    function automatic int draw_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (no_idle || pick < 60) begin
            return 0;
        end else if (pick < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [NOW_W-1:0] ms_since(logic [NOW_W-1:0] now_v,
                                                  logic [NOW_W-1:0] then_v);
        return now_v - then_v;
    endfunction

    function automatic void reset_predictor();
        filt_ms   = RST_FILTER_TIME;
        hold_ms   = RST_LONG_TIME;
        window_ms = '0;
        swap_sel  = 1'b0;
        short_en  = '0;
        long_en   = '0;
        for (int b = 0; b < 3; b++) begin
            stable_lvl[b] = 1'b1;
            chg_ms[b]     = '0;
            press_ms[b]   = '0;
            held_q[b]     = 1'b0;
            fired_q[b]    = 1'b0;
        end
    endfunction

    function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        case (idx)
            CFG_FILTER_TIME:     filt_ms   = val[FILTER_W-1:0];
            CFG_LONG_TIME:       hold_ms   = val[LONG_W-1:0];
            CFG_ACTIVITY_WINDOW: window_ms = val[WINDOW_W-1:0];
            CFG_SWAP_UP_DOWN:    swap_sel  = val[0];
            CFG_SHORT_ENABLE:    short_en  = val[EVENT_W-1:0];
            CFG_LONG_ENABLE:     long_en   = val[EVENT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic t_out_item predict_presses(t_in_item smp);
        t_out_item  res;
        logic [2:0] lvl;
        logic       pushed;
        res    = '0;
        lvl[0] = swap_sel ? smp.level_dn : smp.level_up;
        lvl[1] = smp.level_sel;
        lvl[2] = swap_sel ? smp.level_up : smp.level_dn;
        for (int b = 0; b < 3; b++) begin
            pushed = !lvl[b];
            if (lvl[b] != stable_lvl[b]) begin
                if (pushed && ms_since(smp.now_ms, chg_ms[b]) > filt_ms) begin
                    press_ms[b] = smp.now_ms;
                    held_q[b]   = 1'b1;
                    if (short_en[b] && !long_en[b]) begin
                        res.short_press[b] = 1'b1;
                    end
                end
                chg_ms[b]     = smp.now_ms;
                stable_lvl[b] = lvl[b];
            end else if (!pushed && held_q[b] && ms_since(smp.now_ms, chg_ms[b]) > filt_ms) begin
                if (!fired_q[b] && short_en[b] && long_en[b]) begin
                    res.short_press[b] = 1'b1;
                end
                held_q[b]  = 1'b0;
                fired_q[b] = 1'b0;
            end
            if (!fired_q[b] && long_en[b] && pushed && held_q[b] &&
                    ms_since(smp.now_ms, press_ms[b]) > hold_ms) begin
                fired_q[b]        = 1'b1;
                res.long_press[b] = 1'b1;
            end
            if (ms_since(smp.now_ms, chg_ms[b]) <= window_ms) begin
                res.recently_active = 1'b1;
            end
        end
        res.any_pressed = !smp.level_up || !smp.level_sel || !smp.level_dn;
        return res;
    endfunction

    function automatic void report_mismatch(string what, int exp_v, int act_v);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
            $display("[%0t] %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
        end
    endfunction

    // Driver: presents queued samples at the falling edge.
    always @(negedge i_clk) begin
        logic nxt_valid;
        if (i_rst_n) begin
            nxt_valid = in_valid;
            if (in_fire) begin
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_samples.size() > 0) begin
                    in_item   <= pending_samples.pop_front();
                    nxt_valid = 1'b1;
                    send_gap  = draw_gap();
                end
            end
            in_valid <= nxt_valid;
        end
    end

    // Result side back-pressure, including the long hold-off.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (holdoff_taken < holdoff_asked) begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoff_taken++;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                stall_left = draw_gap();
            end
        end
    end

    // Monitor: predicts on each accepted sample and checks each accepted result.
    always @(posedge i_clk) begin
        t_out_item exp_r;
        t_out_item got_r;
        if (!i_rst_n) begin
            reset_predictor();
            in_fire = 1'b0;
        end else begin
            if (cfg_we) begin
                apply_setting(cfg_idx, cfg_data);
            end
            in_fire = in_valid && o_in_ready;
            if (in_fire) begin
                exp_r = predict_presses(in_item);
                short_cnt += $countones(exp_r.short_press);
                long_cnt  += $countones(exp_r.long_press);
                sent_cnt++;
                press_results.push_back(exp_r);
            end
            if (o_out_valid && out_ready) begin
                got_r = o_out_item;
                if (press_results.size() == 0) begin
                    report_mismatch("result with no sample pending", 0, int'(got_r));
                end else begin
                    exp_r = press_results.pop_front();
                    checked_cnt++;
                    if (got_r.short_press !== exp_r.short_press) begin
                        report_mismatch("short_press", int'(exp_r.short_press),
                                        int'(got_r.short_press));
                    end
                    if (got_r.long_press !== exp_r.long_press) begin
                        report_mismatch("long_press", int'(exp_r.long_press),
                                        int'(got_r.long_press));
                    end
                    if (got_r.any_pressed !== exp_r.any_pressed) begin
                        report_mismatch("any_pressed", int'(exp_r.any_pressed),
                                        int'(got_r.any_pressed));
                    end
                    if (got_r.recently_active !== exp_r.recently_active) begin
                        report_mismatch("recently_active", int'(exp_r.recently_active),
                                        int'(got_r.recently_active));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic push_sample(logic [NOW_W-1:0] t, bit up, bit sel, bit dn);
        t_in_item smp;
        smp.now_ms    = t;
        smp.level_up  = up;
        smp.level_sel = sel;
        smp.level_dn  = dn;
        pending_samples.push_back(smp);
    endtask

    task automatic drain_block();
        while (pending_samples.size() > 0 || in_valid || press_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DAT_W'(val);
    endtask

    task automatic write_settings(int f, int l, int w, int sw, int sm, int lm);
        write_reg(CFG_FILTER_TIME, f);
        write_reg(CFG_LONG_TIME, l);
        write_reg(CFG_ACTIVITY_WINDOW, w);
        write_reg(CFG_SWAP_UP_DOWN, sw);
        write_reg(CFG_SHORT_ENABLE, sm);
        write_reg(CFG_LONG_ENABLE, lm);
        write_reg(CFG_UNMAPPED_A, $urandom());
        write_reg(CFG_UNMAPPED_B, $urandom());
        @(negedge i_clk);
        cfg_we <= 1'b0;
        settings_cnt++;
    endtask

    // Mostly button activity with advancing time, with some wholly random samples.
    task automatic queue_button_activity(int count, int f, int l);
        t_in_item smp;
        int       pick;
        int       delta;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                smp.now_ms    = $urandom();
                smp.level_up  = 1'($urandom_range(0, 1));
                smp.level_sel = 1'($urandom_range(0, 1));
                smp.level_dn  = 1'($urandom_range(0, 1));
                pending_samples.push_back(smp);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    delta = $urandom_range(0, f / 2 + 1);
                end else if (pick < 85) begin
                    delta = $urandom_range(0, f + l / 4 + 2);
                end else begin
                    delta = $urandom_range(l / 2, 2 * l + f + 2);
                end
                cur_ms += NOW_W'(delta);
                for (int b = 0; b < 3; b++) begin
                    if ($urandom_range(0, 5) == 0) begin
                        pin_lvl[b] = !pin_lvl[b];
                    end
                end
                push_sample(cur_ms, pin_lvl[0], pin_lvl[1], pin_lvl[2]);
            end
        end
    endtask

    initial begin
        int f, l, w, sw, sm, lm;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: all events disabled, zero activity window.
        push_sample(32'd0, 1'b0, 1'b0, 1'b0);
        push_sample(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        push_sample(32'd100, 1'b1, 1'b1, 1'b1);
        drain_block();

        write_settings(10, 100, 30, 0, 7, 5);
        push_sample(32'd300, 1'b0, 1'b0, 1'b1);
        push_sample(32'd305, 1'b0, 1'b1, 1'b1);
        push_sample(32'd320, 1'b0, 1'b1, 1'b1);
        push_sample(32'd401, 1'b0, 1'b1, 1'b1);
        push_sample(32'd402, 1'b0, 1'b1, 1'b1);
        push_sample(32'd500, 1'b1, 1'b1, 1'b1);
        push_sample(32'd511, 1'b1, 1'b1, 1'b1);
        push_sample(32'd600, 1'b1, 1'b1, 1'b0);
        push_sample(32'd601, 1'b1, 1'b1, 1'b1);
        push_sample(32'd605, 1'b1, 1'b1, 1'b0);
        push_sample(32'd700, 1'b1, 1'b1, 1'b1);
        push_sample(32'd720, 1'b1, 1'b1, 1'b1);
        push_sample(32'd721, 1'b0, 1'b1, 1'b0);
        push_sample(32'd725, 1'b1, 1'b1, 1'b1);
        push_sample(32'd740, 1'b1, 1'b1, 1'b1);
        push_sample(32'hFFFF_FFF0, 1'b1, 1'b0, 1'b1);
        push_sample(32'h0000_0005, 1'b1, 1'b1, 1'b1);
        push_sample(32'h0000_0020, 1'b1, 1'b1, 1'b1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    f = 0; l = 0; w = 24'hFF_FFFF; sw = 0; sm = 7; lm = 7;
                end
                1: begin
                    f = 65535; l = 65535; w = 0; sw = 1; sm = 5; lm = 7;
                end
                default: begin
                    f  = $urandom_range(0, 40);
                    l  = $urandom_range(0, 300);
                    w  = (ph % 3 == 2) ? $urandom_range(0, 24'hFF_FFFF) : $urandom_range(0, 200);
                    sw = $urandom_range(0, 1);
                    sm = $urandom_range(0, 7);
                    lm = $urandom_range(0, 7);
                end
            endcase
            drain_block();
            write_settings(f, l, w, sw, sm, lm);
            no_idle = (ph == 3);
            if (ph == 2) begin
                holdoff_asked++;
            end
            if (ph == 1 || ph == 4) begin
                cur_ms = 32'hFFFF_FFFF - NOW_W'($urandom_range(0, 500000));
            end else begin
                cur_ms = $urandom();
            end
            queue_button_activity(SAMPLES_PER_SET, f, l);
        end

        drain_block();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (press_results.size() > 0) begin
            report_mismatch("result never delivered", 1, 0);
            void'(press_results.pop_front());
        end

        $display("Run covered %0d samples under %0d register settings, %0d results checked.",
                 sent_cnt, settings_cnt, checked_cnt);
        $display("Predicted %0d short and %0d long press events; %0d mismatches.",
                 short_cnt, long_cnt, mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
